FILE: src/llh_pkg.sv
// Shared types and constants for the log-linear latency histogram.
`default_nettype none
package llh_pkg;

  localparam int unsigned Q16_ONE = 65536;

  // Command codes carried in the cmd field.
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] sample;
    logic [16:0] fraction;
  } llh_in_t;

  typedef struct packed {
    logic [63:0] pct_value;
    logic [63:0] sample_count;
    logic [63:0] sum_total;
    logic [63:0] min_seen;
    logic [63:0] max_seen;
  } llh_out_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_REC_TOP,
    S_REC_IDX,
    S_REC_WR,
    S_Q_MUL0,
    S_Q_MUL1,
    S_Q_RD0,
    S_Q_WALK,
    S_Q_BOUND,
    S_CLR,
    S_DONE
  } llh_state_e;

endpackage
`default_nettype wire

FILE: src/log_linear_latency_histogram_core.sv
// Log-linear latency histogram: bin store, statistics and command sequencer.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+----------------------------------
//  in      | in  | in_valid_i / in_stall_o | llh_in_t  (cmd, sample, fraction)
//  out     | out | out_valid_o/ out_stall_i| llh_out_t (pct, count, sum, min, max)
//
// Record: after the transfer, a two-step top-bit search, a bin read and a bin write.
// Query: two 32x17 multiplier passes, then a walk over the bins at one bin per cycle;
//   an empty histogram goes straight to the result. Clear: one bin per cycle. No-op: straight to the result.
// Reset: all DEPTH = NUM_BUCKETS << SUB_BITS bins of the store are swept, input stalled.
// A finished result sits in the output register while the next command is taken;
//   the sequencer waits in its final state only while a stall still holds that register.
`default_nettype none
module log_linear_latency_histogram_core
  import llh_pkg::*;
#(
  parameter int unsigned SUB_BITS        = 5,
  parameter int unsigned NUM_BUCKETS     = 32,
  parameter int unsigned BIN_COUNT_WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire llh_in_t  in_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output llh_out_t      out_o
);

  localparam int unsigned DEPTH = NUM_BUCKETS << SUB_BITS;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  llh_state_e state_q, state_d;

  logic [BIN_COUNT_WIDTH-1:0] mem [DEPTH];
  logic [BIN_COUNT_WIDTH-1:0] rdata_q;
  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_waddr, mem_raddr;
  logic [BIN_COUNT_WIDTH-1:0] mem_wdata;

  logic [63:0]      samp_q, samp_d;
  logic [16:0]      p_q, p_d;
  logic [2:0]       grp_q, grp_d;
  logic [7:0]       byte_q, byte_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  logic [48:0]      acc_q, acc_d;
  logic [63:0]      target_q, target_d;
  logic [63:0]      run_q, run_d;
  logic [63:0]      pct_q, pct_d;
  logic [63:0]      cnt_q, cnt_d, sum_q, sum_d, min_q, min_d, max_q, max_d;
  llh_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic        in_xfer;
  logic        slot_free;
  logic        hit;
  logic [63:0] run_n;
  logic [64:0] run_add;
  logic [IDX_W-1:0] bin_idx;
  logic [48:0] mul_p;
  logic [31:0] mul_a;
  logic [80:0] prod;
  logic [63:0] bound;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Top-bit search, first step: highest nonzero byte.
  always_comb begin
    grp_d = grp_q;
    byte_d = byte_q;
    if (state_q == S_REC_TOP) begin
      grp_d = 3'd0;
      for (int g = 0; g < 8; g++) begin
        if (|samp_q[g*8 +: 8]) grp_d = 3'(g);
      end
      byte_d = samp_q[{grp_d, 3'b000} +: 8];
    end
  end

  // Second step: bit within the byte, then range and sub-bin.
  always_comb begin
    logic [2:0]  bit_n;
    logic [5:0]  top_n;
    logic [7:0]  r_n;
    logic [5:0]  rng_n;
    logic [63:0] shifted;
    logic [SUB_BITS-1:0] sub_n;
    bit_n = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (byte_q[b]) bit_n = 3'(b);
    end
    top_n   = {grp_q, bit_n};
    r_n     = 8'(top_n) - 8'(SUB_BITS);
    shifted = samp_q >> r_n[5:0];
    if (samp_q[63:1] == 63'd0) begin
      rng_n = 6'd0;
      sub_n = '0;
    end else if (r_n[7]) begin
      rng_n = 6'd0;
      sub_n = SUB_BITS'(samp_q - 64'd1);
    end else if (r_n[6:0] >= 7'(NUM_BUCKETS)) begin
      rng_n = 6'(NUM_BUCKETS - 1);
      sub_n = '1;
    end else begin
      rng_n = r_n[5:0];
      sub_n = shifted[SUB_BITS-1:0];
    end
    bin_idx = (IDX_W'(rng_n) << SUB_BITS) | IDX_W'(sub_n);
  end

  // Shared multiplier for the query target: count * p, 32 bits of count per pass.
  assign mul_a = (state_q == S_Q_MUL0) ? cnt_q[31:0] : cnt_q[63:32];
  assign mul_p = 49'(mul_a) * 49'(p_q);
  assign prod  = {mul_p, 32'd0} + 81'(acc_q);

  // Saturating running sum for the walk.
  assign run_add = 65'(run_q) + 65'(rdata_q);
  assign run_n   = run_add[64] ? '1 : run_add[63:0];
  assign hit     = (run_n >= target_q);

  // Lower bound of the bin at pidx_q.
  always_comb begin
    logic [5:0]          rng_b;
    logic [SUB_BITS-1:0] sub_b;
    rng_b = 6'(pidx_q >> SUB_BITS);
    sub_b = pidx_q[SUB_BITS-1:0];
    if (rng_b == 6'd0) begin
      bound = 64'(sub_b) + 64'd1;
    end else begin
      bound = ((64'd1 << SUB_BITS) | 64'(sub_b)) << rng_b;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (pidx_q == LAST_IDX) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_i.cmd)
            CMD_RECORD: state_d = S_REC_TOP;
            CMD_QUERY:  state_d = (cnt_q == 64'd0) ? S_DONE : S_Q_MUL0;
            CMD_CLEAR:  state_d = S_CLR;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_REC_TOP: state_d = S_REC_IDX;
      S_REC_IDX: state_d = S_REC_WR;
      S_REC_WR:  state_d = S_DONE;
      S_Q_MUL0:  state_d = S_Q_MUL1;
      S_Q_MUL1:  state_d = S_Q_RD0;
      S_Q_RD0:   state_d = S_Q_WALK;
      S_Q_WALK: begin
        if (hit) state_d = S_Q_BOUND;
        else if (pidx_q == LAST_IDX) state_d = S_DONE;
      end
      S_Q_BOUND: state_d = S_DONE;
      S_CLR: begin
        if (pidx_q == LAST_IDX) state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    samp_d      = samp_q;
    p_d         = p_q;
    addr_d      = addr_q;
    pidx_d      = pidx_q;
    acc_d       = acc_q;
    target_d    = target_q;
    run_d       = run_q;
    pct_d       = pct_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = pidx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = bin_idx;
    case (state_q)
      S_INIT, S_CLR: begin
        mem_we = 1'b1;
        pidx_d = pidx_q + IDX_W'(1);
        cnt_d  = 64'd0;
        sum_d  = 64'd0;
        min_d  = '1;
        max_d  = 64'd0;
      end
      S_IDLE: begin
        if (in_xfer) begin
          samp_d = in_i.sample;
          p_d    = (in_i.fraction > 17'(Q16_ONE)) ? 17'(Q16_ONE) : in_i.fraction;
          pct_d  = 64'd0;
          pidx_d = '0;
        end
      end
      S_REC_TOP: begin
        cnt_d = cnt_q + 64'd1;
        sum_d = sum_q + samp_q;
      end
      S_REC_IDX: begin
        mem_re = 1'b1;
        addr_d = bin_idx;
        if (samp_q < min_q) min_d = samp_q;
      end
      S_REC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = (rdata_q == '1) ? rdata_q : rdata_q + BIN_COUNT_WIDTH'(1);
        if (samp_q > max_q) max_d = samp_q;
      end
      S_Q_MUL0: begin
        acc_d = mul_p;
      end
      S_Q_MUL1: begin
        target_d = prod[79:16];
      end
      S_Q_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        pidx_d    = '0;
        run_d     = 64'd0;
      end
      S_Q_WALK: begin
        run_d = run_n;
        if (!hit) begin
          if (pidx_q == LAST_IDX) begin
            pct_d = max_q;  // saturated counts never reached the target
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pidx_q + IDX_W'(1);
            pidx_d    = pidx_q + IDX_W'(1);
          end
        end
      end
      S_Q_BOUND: begin
        pct_d = bound;
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d = '{pct_value: pct_q, sample_count: cnt_q, sum_total: sum_q,
                    min_seen: min_q, max_seen: max_q};
        end
      end
      default: ;
    endcase
  end

  // Bin store.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= 64'd0;
      sum_q       <= 64'd0;
      min_q       <= '1;
      max_q       <= 64'd0;
    end else begin
      state_q     <= state_d;
      pidx_q      <= pidx_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      min_q       <= min_d;
      max_q       <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q   <= samp_d;
    p_q      <= p_d;
    grp_q    <= grp_d;
    byte_q   <= byte_d;
    addr_q   <= addr_d;
    acc_q    <= acc_d;
    target_q <= target_d;
    run_q    <= run_d;
    pct_q    <= pct_d;
    out_q    <= out_d;
  end

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the final state");

  a_xfer_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("accepted command did not start");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cnt_q != 64'd0) |-> min_q <= max_q)
    else $error("minimum above maximum with samples recorded");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_WALK || state_q == S_CLR || state_q == S_INIT) |-> pidx_q <= LAST_IDX)
    else $error("bin pointer past the last bin");

endmodule
`default_nettype wire

FILE: dv/log_linear_latency_histogram_core_tb.sv
// Self-checking testbench for the log-linear latency histogram core.
`default_nettype none
module log_linear_latency_histogram_core_tb;
  import llh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SUB_BITS        = 5;
  localparam int unsigned NUM_BUCKETS     = 32;
  localparam int unsigned BIN_COUNT_WIDTH = 32;
  localparam int unsigned SUBS_PER_RANGE  = 1 << SUB_BITS;
  localparam int unsigned BIN_DEPTH       = NUM_BUCKETS << SUB_BITS;

  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned NUM_RANDOM      = 1000;
  localparam int unsigned QUIET_TAIL      = 150;
  localparam int unsigned PAUSE_AT        = 500;
  localparam int unsigned HOLD_AT         = 300;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = BIN_DEPTH + 32;
  localparam int unsigned WATCHDOG_CYCLES = 20000;

  localparam logic [63:0] ALL_ONES = '1;
  localparam llh_out_t EMPTY_STATS = '{64'd0, 64'd0, 64'd0, ALL_ONES, 64'd0};

  typedef struct packed {
    llh_in_t  item;
    logic     typed;   // result typed in below, else taken from the predictor
    llh_out_t result;
  } stim_row_t;

  localparam int unsigned NUM_DIRECTED = 25;

  stim_row_t dir_table [NUM_DIRECTED] = '{
    '{'{CMD_NOP,    64'd0, 17'd0},       1'b1, EMPTY_STATS},
    '{'{CMD_QUERY,  64'd0, 17'd0},       1'b1, EMPTY_STATS},
    '{'{CMD_QUERY,  64'd0, 17'h10000},   1'b1, EMPTY_STATS},
    '{'{CMD_RECORD, 64'd0, 17'd0},       1'b1, '{64'd0, 64'd1, 64'd0, 64'd0, 64'd0}},
    '{'{CMD_RECORD, ALL_ONES, 17'd0},    1'b1, '{64'd0, 64'd2, ALL_ONES, 64'd0, ALL_ONES}},
    '{'{CMD_QUERY,  64'd0, 17'd0},       1'b1, '{64'd1, 64'd2, ALL_ONES, 64'd0, ALL_ONES}},
    '{'{CMD_QUERY,  64'd0, 17'h10000},   1'b0, '0},
    '{'{CMD_QUERY,  ALL_ONES, 17'h1FFFF}, 1'b0, '0},
    '{'{CMD_RECORD, 64'd1, 17'd0},       1'b0, '0},
    '{'{CMD_RECORD, 64'd2, 17'd0},       1'b0, '0},
    '{'{CMD_RECORD, 64'd31, 17'd0},      1'b0, '0},
    '{'{CMD_RECORD, 64'd32, 17'd0},      1'b0, '0},
    '{'{CMD_RECORD, 64'd63, 17'd0},      1'b0, '0},
    '{'{CMD_RECORD, 64'd64, 17'd0},      1'b0, '0},
    '{'{CMD_RECORD, 64'h10_0000_0000, 17'd0}, 1'b0, '0},
    '{'{CMD_RECORD, 64'h20_0000_0000, 17'd0}, 1'b0, '0},
    '{'{CMD_RECORD, 64'h8000_0000_0000_0000, 17'd0}, 1'b0, '0},
    '{'{CMD_QUERY,  64'd0, 17'd32768},   1'b0, '0},
    '{'{CMD_QUERY,  64'd0, 17'd1},       1'b0, '0},
    '{'{CMD_QUERY,  64'd0, 17'd65535},   1'b0, '0},
    '{'{CMD_NOP,    64'hAAAA_5555_AAAA_5555, 17'h1FFFF}, 1'b0, '0},
    '{'{CMD_CLEAR,  64'h5555_AAAA_5555_AAAA, 17'h0AAAA}, 1'b1, EMPTY_STATS},
    '{'{CMD_QUERY,  64'd0, 17'h10000},   1'b1, EMPTY_STATS},
    '{'{CMD_RECORD, 64'h5555_AAAA_0F0F_F0F0, 17'd0}, 1'b0, '0},
    '{'{CMD_QUERY,  64'd0, 17'h10000},   1'b0, '0}
  };

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  llh_in_t  in_i        = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  llh_out_t out_o;

  // histogram mirror
  logic [BIN_COUNT_WIDTH-1:0] bin_hits [BIN_DEPTH];
  logic [63:0] n_samples;
  logic [63:0] sample_sum;
  logic [63:0] min_sample;
  logic [63:0] max_sample;

  llh_out_t    result_q [$];
  int unsigned n_errors       = 0;
  int unsigned n_in_accepted  = 0;
  bit          idling         = 1'b1;
  bit          rx_hold        = 1'b0;
  bit          long_hold_done = 1'b0;

  log_linear_latency_histogram_core #(
    .SUB_BITS        (SUB_BITS),
    .NUM_BUCKETS     (NUM_BUCKETS),
    .BIN_COUNT_WIDTH (BIN_COUNT_WIDTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always #1ns clk_i = ~clk_i;

  function automatic void reset_histogram();
    for (int b = 0; b < BIN_DEPTH; b++) bin_hits[b] = '0;
    n_samples  = '0;
    sample_sum = '0;
    min_sample = ALL_ONES;
    max_sample = '0;
  endfunction

  function automatic int unsigned bin_of_latency(logic [63:0] v);
    int top_bit;
    int r;
    if (v <= 64'd1) return 0;
    top_bit = 63;
    while (top_bit > 0 && !v[top_bit]) top_bit--;
    r = top_bit - int'(SUB_BITS);
    if (r < 0) return 32'(v - 64'd1) & (SUBS_PER_RANGE - 1);
    if (r >= int'(NUM_BUCKETS)) return BIN_DEPTH - 1;
    return r * SUBS_PER_RANGE + 32'((v >> r) & 64'(SUBS_PER_RANGE - 1));
  endfunction

  function automatic logic [63:0] percentile_bound(logic [16:0] frac);
    logic [63:0] p;
    logic [63:0] target;
    logic [63:0] running;
    logic [63:0] c;
    int unsigned rng;
    int unsigned sub;
    if (n_samples == 0) return 64'd0;
    p = (frac > Q16_ONE) ? 64'(Q16_ONE) : 64'(frac);
    // exact floor(p * count / 2^16) without a 81-bit product
    target = (n_samples >> 16) * p + (((n_samples & 64'hFFFF) * p) >> 16);
    running = '0;
    for (int b = 0; b < BIN_DEPTH; b++) begin
      c = 64'(bin_hits[b]);
      running = (running > ALL_ONES - c) ? ALL_ONES : running + c;
      if (running >= target) begin
        rng = b / SUBS_PER_RANGE;
        sub = b % SUBS_PER_RANGE;
        if (rng == 0) return 64'(sub) + 64'd1;
        return 64'(SUBS_PER_RANGE + sub) << rng;
      end
    end
    return max_sample;  // only reachable once bin counts have saturated
  endfunction

  function automatic llh_out_t apply_command(llh_in_t item);
    llh_out_t r;
    int unsigned b;
    r.pct_value = '0;
    case (item.cmd)
      CMD_RECORD: begin
        b = bin_of_latency(item.sample);
        if (bin_hits[b] != '1) bin_hits[b] = bin_hits[b] + 1'b1;
        n_samples  = n_samples + 64'd1;
        sample_sum = sample_sum + item.sample;
        if (item.sample < min_sample) min_sample = item.sample;
        if (item.sample > max_sample) max_sample = item.sample;
      end
      CMD_QUERY: r.pct_value = percentile_bound(item.fraction);
      CMD_CLEAR: reset_histogram();
      default: ;
    endcase
    r.sample_count = n_samples;
    r.sum_total    = sample_sum;
    r.min_seen     = min_sample;
    r.max_seen     = max_sample;
    return r;
  endfunction

  task automatic send_transfer(input llh_in_t item, input bit typed, input llh_out_t typed_result);
    llh_out_t want;
    in_valid_i <= 1'b1;
    in_i       <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    want = apply_command(item);
    result_q.push_back(typed ? typed_result : want);
    n_in_accepted++;
  endtask

  // Called right after a transfer, in the same time step.
  task automatic sender_gap(input bit drain);
    if (drain) begin
      in_valid_i <= 1'b0;
      while (result_q.size() != 0) @(posedge clk_i);
    end else if (idling && !rx_hold && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  initial begin : stimulus
    llh_in_t     item;
    logic [63:0] v;
    int unsigned pick;
    reset_histogram();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_transfer(dir_table[i].item, dir_table[i].typed, dir_table[i].result);
      sender_gap(i == NUM_DIRECTED - 1);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - QUIET_TAIL) idling = 1'b0;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0:       v = 64'($urandom_range(0, 70));
        1:       v = ($urandom_range(0, 1) != 0) ? ALL_ONES : 64'd0;
        2, 3:    v = v >> $urandom_range(0, 63);
        default: v = v >> $urandom_range(24, 63);  // mostly inside the log ranges
      endcase
      item.sample = v;
      case ($urandom_range(0, 9))
        0:       item.fraction = 17'd0;
        1:       item.fraction = 17'(Q16_ONE);
        2:       item.fraction = 17'($urandom_range(Q16_ONE + 1, 17'h1FFFF));
        default: item.fraction = 17'($urandom_range(0, Q16_ONE));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 78)      item.cmd = CMD_RECORD;
      else if (pick < 90) item.cmd = CMD_QUERY;
      else if (pick < 98) item.cmd = CMD_NOP;
      else                item.cmd = CMD_CLEAR;
      send_transfer(item, 1'b0, '0);
      sender_gap(i == PAUSE_AT);
    end

    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("** log_linear_latency_histogram_core: PASSED **");
    end else begin
      $display("** log_linear_latency_histogram_core: FAILED **");
    end
    $finish;
  end

  // Receiver: random stall bursts plus one long hold-off that backs up the core.
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && n_in_accepted >= HOLD_AT) begin
        rx_hold = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        rx_hold = 1'b0;
        long_hold_done = 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : result_checker
    llh_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (result_q.size() == 0) begin
          $display("%0t ns: unexpected transfer, expected none, actual %h", $time, out_o);
          n_errors++;
        end else begin
          want = result_q.pop_front();
          check_field("pct_value",    want.pct_value,    out_o.pct_value);
          check_field("sample_count", want.sample_count, out_o.sample_count);
          check_field("sum_total",    want.sum_total,    out_o.sum_total);
          check_field("min_seen",     want.min_seen,     out_o.min_seen);
          check_field("max_seen",     want.max_seen,     out_o.max_seen);
        end
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t ns: timeout, %0d results still expected", $time, result_q.size());
    $display("** log_linear_latency_histogram_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
